// File: rtl/bfr_pkg.sv
// shared types and constants for the bitmap font text renderer
package bfr_pkg;

	// default glyph geometry, font size and queue depth
	localparam int GLYPH_WIDTH_DEF  = 8;
	localparam int GLYPH_HEIGHT_DEF = 8;
	localparam int GLYPH_COUNT_DEF  = 128;
	localparam int QUEUE_DEPTH_DEF  = 4;

	// field widths
	localparam int ROW_W        = 3;
	localparam int CODE_FIELD_W = 7;
	localparam int IN_DATA_W    = 56;
	localparam int OUT_DATA_W   = 40;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;

	// character codes with special meaning
	localparam logic [7:0] NULL_CODE    = 8'd0;
	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	// cursor y limit
	localparam logic [16:0] Y_LIMIT = 17'd65535;

	// request kind
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_DRAW = 1'b1
	} op_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_BASE   = 2'd0,
		CFG_LINE_PITCH   = 2'd1,
		CFG_SCREEN_WIDTH = 2'd2
	} cfg_idx_t;

	// configuration register set
	typedef struct packed {
		logic [31:0] frame_base;
		logic [15:0] line_pitch;
		logic [15:0] screen_width;
	} cfg_t;

	// work handed from the front to the back
	typedef struct packed {
		op_t                     op;
		logic [CODE_FIELD_W-1:0] code;
		logic [ROW_W-1:0]        row;
		logic [7:0]              bits;
		logic [15:0]             x;
		logic [15:0]             y;
		logic [7:0]              color;
	} entry_t;

	// back status seen by the top level
	typedef struct packed {
		logic busy;
		logic out_load;
	} bk_status_t;

endpackage

// File: rtl/bfr_ram.sv
// generic single-write, single-read ram with registered read data
module bfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds its data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/bfr_queue.sv
// short fifo of work entries between the front and the back
module bfr_queue import bfr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	output logic   full,
	output logic   valid,
	output entry_t rd_entry,
	input  logic   pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign valid    = (cnt_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/bfr_front.sv
// front: accepts requests, keeps the text cursor and queues glyph work
module bfr_front import bfr_pkg::*; #(
	parameter int GLYPH_WIDTH  = GLYPH_WIDTH_DEF,
	parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
	parameter int GLYPH_COUNT  = GLYPH_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic [0:0]           s_tuser,
	output logic                 push,
	output entry_t               entry,
	input  logic                 full
);

	logic        accept;
	op_t         op;
	logic [7:0]  code;
	logic [2:0]  frow;
	logic [7:0]  fbits;
	logic        start;
	logic [12:0] scol;
	logic [12:0] srow;
	logic [7:0]  color;

	logic [15:0] cur_x_q;
	logic [15:0] cur_y_q;
	logic [15:0] line_x_q;

	logic [15:0] x_start;
	logic [15:0] y_start;
	logic [15:0] ls_start;
	logic [15:0] next_x;
	logic [15:0] next_y;
	logic [16:0] adv_x;

	// saturating move down by one glyph height
	function automatic logic [15:0] step_down(input logic [15:0] y);
		logic [16:0] n;
		n = 17'(y) + 17'(GLYPH_HEIGHT);
		return (n > Y_LIMIT) ? Y_LIMIT[15:0] : n[15:0];
	endfunction

	// request fields
	assign op     = op_t'(s_tuser[0]);
	assign code   = s_tdata[7:0];
	assign frow   = s_tdata[10:8];
	assign fbits  = s_tdata[18:11];
	assign start  = s_tdata[19];
	assign scol   = s_tdata[32:20];
	assign srow   = s_tdata[45:33];
	assign color  = s_tdata[53:46];

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	// cursor after an optional reload
	assign x_start  = start ? {scol, 3'b000} : cur_x_q;
	assign y_start  = start ? {srow, 3'b000} : cur_y_q;
	assign ls_start = start ? {scol, 3'b000} : line_x_q;
	assign adv_x    = 17'(x_start) + 17'(GLYPH_WIDTH);

	// classify the request and work out the next cursor
	always_comb begin
		next_x = x_start;
		next_y = y_start;
		push   = 1'b0;
		if (op == OP_LOAD) begin
			push = accept && (code < 8'(GLYPH_COUNT)) && ({1'b0, frow} < 4'(GLYPH_HEIGHT));
		end else if (code == NULL_CODE) begin
			next_x = x_start;
		end else if (code == NEWLINE_CODE) begin
			next_x = '0;
			next_y = step_down(y_start);
		end else begin
			push = accept && (code < 8'(GLYPH_COUNT));
			if (adv_x >= {1'b0, cfg.screen_width}) begin
				next_x = ls_start;
				next_y = step_down(y_start);
			end else begin
				next_x = adv_x[15:0];
			end
		end
	end

	// queue entry
	always_comb begin
		entry.op    = op;
		entry.code  = code[CODE_FIELD_W-1:0];
		entry.row   = frow;
		entry.bits  = fbits;
		entry.x     = x_start;
		entry.y     = y_start;
		entry.color = color;
	end

	// cursor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			line_x_q <= '0;
		end else if (accept && op == OP_DRAW) begin
			cur_x_q  <= next_x;
			cur_y_q  <= next_y;
			line_x_q <= ls_start;
		end
	end

endmodule

// File: rtl/bfr_back.sv
// back: owns the glyph store, loads rows and scans glyphs into pixel writes
module bfr_back import bfr_pkg::*; #(
	parameter int GLYPH_WIDTH  = GLYPH_WIDTH_DEF,
	parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
	parameter int GLYPH_COUNT  = GLYPH_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  q_valid,
	input  entry_t                q_entry,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,
	output bk_status_t            status
);

	localparam int CODE_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
	localparam int ADDR_W = CODE_W + ROW_W;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam logic [7:0] COL_MASK = 8'((1 << GLYPH_WIDTH) - 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_HEIGHT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SCAN
	} state_t;

	state_t             state_q;
	logic [CODE_W-1:0]  code_q;
	logic [15:0]        x_q;
	logic [15:0]        y_q;
	logic [7:0]         color_q;
	logic [ROW_W-1:0]   row_q;
	logic [7:0]         mask_q;
	logic [31:0]        row_base_q;
	logic               pend_v_q;
	logic [31:0]        pend_addr_q;
	logic [7:0]         pend_val_q;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [7:0]         ram_rdata;

	logic [16:0]        line_d;
	logic [32:0]        prod_d;
	logic [31:0]        row_base_d;
	logic [7:0]         avail;
	logic [2:0]         col;
	logic [31:0]        pix_addr;
	logic               out_free;
	logic               fire;
	logic               finish;
	logic               out_load;

	// index of the lowest set bit
	function automatic logic [2:0] lowest_set(input logic [7:0] v);
		logic [2:0] idx;
		idx = '0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) idx = 3'(i);
		end
		return idx;
	endfunction

	// glyph store
	bfr_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (q_entry.bits),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// dequeue, load and fetch control
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign ram_we    = q_pop && (q_entry.op == OP_LOAD);
	assign ram_waddr = {q_entry.code[CODE_W-1:0], q_entry.row};
	assign ram_re    = (state_q == ST_FETCH);
	assign ram_raddr = {code_q, row_q};

	// address of the current glyph row's first column
	assign line_d     = 17'(y_q) + 17'(row_q);
	assign prod_d     = 33'(line_d) * 33'(cfg.line_pitch);
	assign row_base_d = cfg.frame_base + prod_d[31:0] + 32'(x_q);

	// column scan, one lit pixel per cycle while the output is not stalled
	assign avail    = ram_rdata & COL_MASK & ~mask_q;
	assign col      = lowest_set(avail);
	assign pix_addr = row_base_q + 32'(col);
	assign out_free = !m_tvalid || m_tready;
	assign fire     = (state_q == ST_SCAN) && (avail != '0) && (!pend_v_q || out_free);
	assign finish   = (state_q == ST_SCAN) && (avail == '0) && (row_q == LAST_ROW)
	                  && (!pend_v_q || out_free);
	assign out_load = (fire || finish) && pend_v_q;

	assign status.busy     = (state_q != ST_IDLE);
	assign status.out_load = out_load;

	// sequencer, pending pixel and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			code_q      <= '0;
			x_q         <= '0;
			y_q         <= '0;
			color_q     <= '0;
			row_q       <= '0;
			mask_q      <= '0;
			row_base_q  <= '0;
			pend_v_q    <= 1'b0;
			pend_addr_q <= '0;
			pend_val_q  <= '0;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
			m_tlast     <= 1'b0;
		end else begin
			// held pixel moves out, marked last when the glyph is done
			if (out_load) begin
				m_tvalid <= 1'b1;
				m_tdata  <= {pend_val_q, pend_addr_q};
				m_tlast  <= finish;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && q_entry.op == OP_DRAW) begin
						code_q  <= q_entry.code[CODE_W-1:0];
						x_q     <= q_entry.x;
						y_q     <= q_entry.y;
						color_q <= q_entry.color;
						row_q   <= '0;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					row_base_q <= row_base_d;
					mask_q     <= '0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					if (fire) begin
						mask_q[col] <= 1'b1;
						pend_v_q    <= 1'b1;
						pend_addr_q <= pix_addr;
						pend_val_q  <= color_q;
					end else if (avail == '0) begin
						if (row_q != LAST_ROW) begin
							row_q   <= row_q + 1'b1;
							state_q <= ST_FETCH;
						end else if (finish) begin
							pend_v_q <= 1'b0;
							state_q  <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/bitmap_font_text_renderer_core.sv
// top level of the bitmap font text renderer: registers, front, queue and back
//
// Renders 8x8 bitmap text into an 8-bit linear framebuffer. Each request on the
// slave stream is either a font row load (tuser 0) or a character draw (tuser 1);
// the front takes one request per cycle while the queue has room, keeps the text
// cursor, and forwards loads and drawable glyphs to the back. The back owns the
// glyph store, executes entries in order, and emits at most one pixel write per
// cycle on the master stream while it is not stalled, with tlast on the final
// write of each character. A load is written to the glyph store as it is
// dequeued; a drawn glyph is dequeued, then for each glyph row the back fetches
// the row from the glyph store, emits its lit pixels and closes the row. The back
// does not dequeue the next entry until the current glyph is done. Newline,
// code 0 and codes without a glyph never reach the back; they only update the
// cursor. The glyph store is not cleared after reset; every glyph must be loaded
// before it is drawn. The user must write configuration only while the block is
// idle; the block itself does not enforce this.
module bitmap_font_text_renderer_core import bfr_pkg::*; #(
	parameter int GLYPH_WIDTH  = GLYPH_WIDTH_DEF,
	parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
	parameter int GLYPH_COUNT  = GLYPH_COUNT_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// char_code[7:0] font_row[10:8] font_bits[18:11] start_flag[19]
	// start_col[32:20] start_row[45:33] color[53:46], zero above
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// operation[0]
	input  logic [0:0]            s_tuser,
	// pixel write stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// pixel_address[31:0] pixel_value[39:32]
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	cfg_t       cfg_q;
	logic       q_push;
	entry_t     q_wr_entry;
	logic       q_full;
	logic       q_valid;
	entry_t     q_rd_entry;
	logic       q_pop;
	bk_status_t bk_status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_base   <= 32'd0;
			cfg_q.line_pitch   <= 16'd1024;
			cfg_q.screen_width <= 16'd1024;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_BASE:   cfg_q.frame_base   <= cfg_data;
				CFG_LINE_PITCH:   cfg_q.line_pitch   <= cfg_data[15:0];
				CFG_SCREEN_WIDTH: cfg_q.screen_width <= cfg_data[15:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// request intake and cursor
	bfr_front #(
		.GLYPH_WIDTH  (GLYPH_WIDTH),
		.GLYPH_HEIGHT (GLYPH_HEIGHT),
		.GLYPH_COUNT  (GLYPH_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (q_push),
		.entry    (q_wr_entry),
		.full     (q_full)
	);

	// work queue
	bfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.full     (q_full),
		.valid    (q_valid),
		.rd_entry (q_rd_entry),
		.pop      (q_pop)
	);

	// glyph store and pixel scan
	bfr_back #(
		.GLYPH_WIDTH  (GLYPH_WIDTH),
		.GLYPH_HEIGHT (GLYPH_HEIGHT),
		.GLYPH_COUNT  (GLYPH_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_entry  (q_rd_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.status   (bk_status)
	);

	// the front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into full queue");

	// the back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	// a held pixel write is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.out_load |-> (!m_tvalid || m_tready))
		else $error("pending pixel write overwritten");

	// pixel writes come only from an active glyph scan
	a_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!bk_status.busy |-> !bk_status.out_load)
		else $error("pixel write while back idle");

endmodule
